[rtl/assert_macros.svh]
// Assertion macros shared by the frame packetizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tfp_pkg.sv]
// Package: constants, types and helper functions of the tensor frame packetizer.
package tfp_pkg;

  localparam int PAYLOAD_BYTES     = 1500;
  localparam int MIN_PAYLOAD_BYTES = 64;
  localparam int ELEMS_PER_FRAME   = (PAYLOAD_BYTES / 4) * 2;
  localparam int MIN_EVEN_BYTES    = (MIN_PAYLOAD_BYTES + 1) / 2 * 2;
  localparam int HDR_WORDS         = 7;

  localparam int MAC_W    = 48;
  localparam int TLEN_W   = 24;
  localparam int SAMPLE_W = 32;
  localparam int Q_W      = 16;
  localparam int SLOT_W   = $clog2(ELEMS_PER_FRAME + 1);
  localparam int BYTES_W  = $clog2(2 * ELEMS_PER_FRAME + 4);
  localparam int PAD_W    = $clog2(MIN_EVEN_BYTES / 2 + 1);
  localparam int WIDX_W   = $clog2(HDR_WORDS + 1 + MIN_EVEN_BYTES / 2 + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [MAC_W-1:0]  MAC_RST    = 48'h010203040506;
  localparam logic [TLEN_W-1:0] TENSOR_RST = 24'd1;

  // Register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TENSOR_ELEMENTS = 2'd2;

  // Descriptor of one accepted sample: everything per sample that the word emitter needs
  typedef struct packed {
    logic [Q_W-1:0]     q;
    logic               hdr;
    logic [BYTES_W-1:0] hlen;
    logic [PAD_W-1:0]   pad;
    logic               fdone;
    logic               tdone;
  } job_t;

  // One 16-bit wire word with its markers
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       frame_end;
    logic       tensor_end;
    logic       run_last;
  } word_t;

  // Payload byte count: round 2*cnt up to a multiple of 4, then the minimum
  function automatic logic [BYTES_W-1:0] payload_for(input logic [SLOT_W-1:0] cnt);
    logic [BYTES_W-1:0] b;
    b = (BYTES_W'({cnt, 1'b0}) + BYTES_W'(3)) & ~BYTES_W'(3);
    if (b < BYTES_W'(MIN_EVEN_BYTES)) begin
      b = BYTES_W'(MIN_EVEN_BYTES);
    end
    return b;
  endfunction

  // Q16.16 -> Q8.8: (s + 128) / 256 toward zero, saturated
  function automatic logic [Q_W-1:0] to_q8_8(input logic signed [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W:0]   t;
    logic signed [SAMPLE_W:0]   u;
    logic signed [SAMPLE_W-8:0] q;
    logic [Q_W-1:0]             r;
    t = {s[SAMPLE_W-1], s} + 33'sd128;
    u = t[SAMPLE_W] ? (t + 33'sd255) : t;
    q = u[SAMPLE_W:8];
    if (q > 25'sd32767) begin
      r = 16'h7FFF;
    end else if (q < -25'sd32768) begin
      r = 16'h8000;
    end else begin
      r = q[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/tfp_frame_ctl.sv]
// Frame and tensor position counters; builds the descriptor of each sample.
`include "assert_macros.svh"

module tfp_frame_ctl (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic signed [tfp_pkg::SAMPLE_W-1:0]    sample,
  input  logic        [tfp_pkg::TLEN_W-1:0]      tensor_elements,
  input  logic                                   reload,
  output tfp_pkg::job_t                          job
);
  import tfp_pkg::*;

  logic [TLEN_W-1:0] elements_left, elements_left_next;
  logic [SLOT_W-1:0] slot_in_frame, slot_in_frame_next;

  logic [TLEN_W-1:0]  tlen;
  logic [TLEN_W-1:0]  el;
  logic [TLEN_W-1:0]  el_dec;
  logic [SLOT_W-1:0]  cnt;
  logic [SLOT_W-1:0]  slot_inc;
  logic [BYTES_W-1:0] tail_bytes;
  logic [BYTES_W-1:0] pad_bytes;
  logic               tdone;
  logic               fdone;

  always_comb begin
    tlen       = (tensor_elements == '0) ? TLEN_W'(1) : tensor_elements;
    el         = (elements_left == '0) ? tlen : elements_left;
    el_dec     = el - TLEN_W'(1);
    cnt        = (el < TLEN_W'(ELEMS_PER_FRAME)) ? el[SLOT_W-1:0] : SLOT_W'(ELEMS_PER_FRAME);
    slot_inc   = slot_in_frame + SLOT_W'(1);
    tdone      = (el_dec == '0);
    fdone      = tdone || (slot_inc >= SLOT_W'(ELEMS_PER_FRAME));
    tail_bytes = payload_for(slot_inc);
    pad_bytes  = tail_bytes - BYTES_W'({slot_inc, 1'b0});

    job.q     = to_q8_8(sample);
    job.hdr   = (slot_in_frame == '0);
    job.hlen  = payload_for(cnt);
    job.pad   = fdone ? pad_bytes[PAD_W:1] : '0;
    job.fdone = fdone;
    job.tdone = tdone;

    slot_in_frame_next = fdone ? '0 : slot_inc;
    elements_left_next = tdone ? tlen : el_dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elements_left <= TENSOR_RST;
      slot_in_frame <= '0;
    end else if (reload) begin
      elements_left <= tlen;
      slot_in_frame <= '0;
    end else if (accept) begin
      elements_left <= elements_left_next;
      slot_in_frame <= slot_in_frame_next;
    end
  end

  `TFP_ASSERT(a_slot_range, slot_in_frame < SLOT_W'(ELEMS_PER_FRAME), "slot past frame size")
  `TFP_ASSERT(a_left_nonzero, $past(accept) |-> elements_left != '0, "element count ran out")

endmodule

[rtl/tfp_word_emit.sv]
// Sample descriptor register and wire word sequencer with output register.
`include "assert_macros.svh"

module tfp_word_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  tfp_pkg::job_t                 job_in,
  input  logic                          job_load,
  output logic                          job_ready,
  input  logic [tfp_pkg::MAC_W-1:0]     dest_mac,
  input  logic [tfp_pkg::MAC_W-1:0]     source_mac,
  output logic                          word_valid,
  input  logic                          word_ready,
  output tfp_pkg::word_t                word
);
  import tfp_pkg::*;

  job_t              job;
  logic              job_valid;
  logic [WIDX_W-1:0] widx;

  logic              out_load;
  logic              emit;
  logic              at_last;
  logic [WIDX_W-1:0] last_idx;
  logic [WIDX_W-1:0] elem_idx;
  logic [15:0]       hdr_word;
  word_t             word_next;

  always_comb begin
    case (widx)
      WIDX_W'(0): hdr_word = dest_mac[47:32];
      WIDX_W'(1): hdr_word = dest_mac[31:16];
      WIDX_W'(2): hdr_word = dest_mac[15:0];
      WIDX_W'(3): hdr_word = source_mac[47:32];
      WIDX_W'(4): hdr_word = source_mac[31:16];
      WIDX_W'(5): hdr_word = source_mac[15:0];
      default:    hdr_word = 16'(job.hlen);
    endcase
  end

  always_comb begin
    out_load  = !word_valid || word_ready;
    emit      = job_valid && out_load;
    elem_idx  = job.hdr ? WIDX_W'(HDR_WORDS) : '0;
    last_idx  = elem_idx + WIDX_W'(job.pad);
    at_last   = (widx == last_idx);
    job_ready = !job_valid || (emit && at_last);

    if (job.hdr && (widx < WIDX_W'(HDR_WORDS))) begin
      word_next.first  = hdr_word[15:8];
      word_next.second = hdr_word[7:0];
    end else if (widx == elem_idx) begin
      word_next.first  = job.q[7:0];
      word_next.second = job.q[15:8];
    end else begin
      word_next.first  = '0;
      word_next.second = '0;
    end
    word_next.frame_end  = at_last && job.fdone;
    word_next.tensor_end = at_last && job.tdone;
    word_next.run_last   = at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid  <= 1'b0;
      word_valid <= 1'b0;
    end else begin
      if (job_load) begin
        job_valid <= 1'b1;
      end else if (emit && at_last) begin
        job_valid <= 1'b0;
      end
      if (out_load) begin
        word_valid <= job_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job  <= job_in;
      widx <= '0;
    end else if (emit) begin
      widx <= widx + WIDX_W'(1);
    end
    if (emit) begin
      word <= word_next;
    end
  end

  `TFP_ASSERT(a_widx_bound, job_valid |-> widx <= last_idx, "word index past end of item")
  `TFP_ASSERT(a_tensor_end_marks, word_valid && word.tensor_end |-> word.frame_end && word.run_last, "tensor end without frame end")
  `TFP_ASSERT(a_load_when_free, job_load |-> job_ready, "descriptor overwritten")
  `TFP_ASSERT_ALWAYS(a_reset_empty, rst |=> !word_valid && !job_valid, "not empty after reset")

endmodule

[rtl/tensor_frame_packetizer.sv]
// Top level of the tensor frame packetizer: config registers and channel wiring.
//
// Input channel (sample_valid / sample_ready / sample): one signed Q16.16
// tensor element per transfer. Each element becomes a Q8.8 word,
// (sample + 128) / 256 rounded toward zero and saturated.
// Output channel (word_valid / word_ready): one 16-bit wire word per transfer,
// wire_byte_first then wire_byte_second. A frame is 7 header words (dest MAC,
// source MAC, big-endian payload length), up to 750 element words, then zero
// pad words; frame_end, tensor_end and run_last mark last words.
// Config port (cfg_we / cfg_index / cfg_data): 0 dest MAC, 1 source MAC,
// 2 tensor length; writing the length restarts the tensor and frame counts.
// An element waits in the descriptor register after its transfer; its first word is
// then valid in the output word register and can leave from there.
// With samples arriving and the receiver ready, the output is one wire word per
// cycle, set by the single output word register. An element mid-frame is 1 word;
// one opening a frame adds 7 header words, one closing it up to 31 pad words (39 max).
// sample_ready stays high while the descriptor register is free or drains now.
// Reset empties both registers and loads the default MACs and a length of 1.
// A stalled receiver holds the output word; the sequencer and input wait.
module tensor_frame_packetizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [tfp_pkg::SAMPLE_W-1:0] sample,
  output logic                                word_valid,
  input  logic                                word_ready,
  output logic [7:0]                          wire_byte_first,
  output logic [7:0]                          wire_byte_second,
  output logic                                frame_end,
  output logic                                tensor_end,
  output logic                                run_last,
  input  logic                                cfg_we,
  input  logic [tfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tfp_pkg::MAC_W-1:0]           cfg_data
);
  import tfp_pkg::*;

  // Config registers
  logic [MAC_W-1:0]  dest_mac;
  logic [MAC_W-1:0]  source_mac;
  logic [TLEN_W-1:0] tensor_elements;

  logic  accept;
  logic  reload;
  job_t  job;
  word_t word;

  assign accept = sample_valid && sample_ready;
  assign reload = cfg_we && (cfg_index == REG_TENSOR_ELEMENTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_mac        <= MAC_RST;
      source_mac      <= MAC_RST;
      tensor_elements <= TENSOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_MAC:        dest_mac        <= cfg_data;
        REG_SOURCE_MAC:      source_mac      <= cfg_data;
        REG_TENSOR_ELEMENTS: tensor_elements <= cfg_data[TLEN_W-1:0];
        default: ;  // unmapped index: write is dropped
      endcase
    end
  end

  // Position counters; reload uses the new length, so feed it straight from the bus
  tfp_frame_ctl u_ctl (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .sample          (sample),
    .tensor_elements (reload ? cfg_data[TLEN_W-1:0] : tensor_elements),
    .reload          (reload),
    .job             (job)
  );

  tfp_word_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .job_in     (job),
    .job_load   (accept),
    .job_ready  (sample_ready),
    .dest_mac   (dest_mac),
    .source_mac (source_mac),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

  assign wire_byte_first  = word.first;
  assign wire_byte_second = word.second;
  assign frame_end        = word.frame_end;
  assign tensor_end       = word.tensor_end;
  assign run_last         = word.run_last;

endmodule
